/* src/sph_spiky_gradient_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the spiky kernel gradient core
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPH_SPIKY_GRADIENT_CORE_DEFINES_SVH
`define SPH_SPIKY_GRADIENT_CORE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SPG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never holds.
`define SPG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* src/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// Types and constants shared by the spiky kernel gradient core.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumLanes        = 3;
  localparam int unsigned SepW            = 32;
  localparam int unsigned SqW             = 64;
  localparam int unsigned RootW           = 32;
  localparam int unsigned RadiusW         = 31;
  localparam int unsigned ScaleW          = 48;
  localparam int unsigned GradW           = 48;
  localparam int unsigned CfgIdxW         = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgKernelRadius = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgKernelScale  = 8'd1;

  localparam logic [RadiusW-1:0] RadiusReset = 31'd65536;
  localparam logic [ScaleW-1:0]  ScaleReset  = 48'd938734;

  // Per-item data carried alongside the square root pipeline
  typedef struct packed {
    logic [NumLanes-1:0]           neg;
    logic [NumLanes-1:0][SepW-1:0] mag;
  } sqrt_sb_t;

endpackage

/* src/spg_isqrt.sv */
// ----------------------------------------------------------------------------
// spg_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module spg_isqrt #(
  parameter int unsigned SbW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [spg_pkg::SqW-1:0]   rad_i,
  input  logic [SbW-1:0]            sb_i,
  output logic                      valid_o,
  output logic [spg_pkg::RootW-1:0] root_o,
  output logic [SbW-1:0]            sb_o
);

  localparam int unsigned Steps = spg_pkg::RootW;
  localparam int unsigned SqW   = spg_pkg::SqW;

  logic                 valid_q [Steps];
  logic [SqW-1:0]       rem_q   [Steps];
  logic [Steps-1:0]     root_q  [Steps];
  logic [SbW-1:0]       sb_q    [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned B = Steps - 1 - k;
    logic             vin;
    logic [SqW-1:0]   rin;
    logic [Steps-1:0] oin;
    logic [SbW-1:0]   sin;
    logic [SqW-1:0]   trial;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rad_i;
      assign oin = '0;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign rin = rem_q[k-1];
      assign oin = root_q[k-1];
      assign sin = sb_q[k-1];
    end

    // Trial value 2*root*2^B + 2^(2B) for the current bit
    assign trial = (SqW'(oin) << (B + 1)) | (SqW'(1) << (2 * B));

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    // Decide one root bit
    always_ff @(posedge clk_i) begin
      sb_q[k] <= sin;
      if (rin >= trial) begin
        rem_q[k]  <= rin - trial;
        root_q[k] <= oin | (Steps'(1) << B);
      end else begin
        rem_q[k]  <= rin;
        root_q[k] <= oin;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign sb_o    = sb_q[Steps-1];

endmodule

/* src/spg_div3.sv */
// ----------------------------------------------------------------------------
// spg_div3
// Pipelined restoring divider, three lanes over one shared divisor.
// ----------------------------------------------------------------------------
module spg_div3 #(
  parameter int unsigned FRAC_BITS = spg_pkg::FracBitsDefault,
  parameter int unsigned SbW       = 1
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic [spg_pkg::NumLanes-1:0][spg_pkg::SepW-1:0]     num_i,
  input  logic [spg_pkg::RootW-1:0]                           den_i,
  input  logic [SbW-1:0]                                      sb_i,
  output logic                                                valid_o,
  output logic [spg_pkg::NumLanes-1:0][FRAC_BITS:0]           quo_o,
  output logic [SbW-1:0]                                      sb_o
);

  localparam int unsigned Lanes = spg_pkg::NumLanes;
  localparam int unsigned UW    = FRAC_BITS + 1;
  localparam int unsigned RW    = spg_pkg::RootW + FRAC_BITS + 1;
  localparam int unsigned DenW  = spg_pkg::RootW;

  logic            valid_q [UW];
  logic [DenW-1:0] den_q   [UW];
  logic [SbW-1:0]  sb_q    [UW];
  logic [RW-1:0]   rem_q   [UW][Lanes];
  logic [UW-1:0]   quo_q   [UW][Lanes];

  for (genvar k = 0; k < UW; k++) begin : g_step
    localparam int unsigned J = UW - 1 - k;
    logic            vin;
    logic [DenW-1:0] din;
    logic [SbW-1:0]  sin;
    logic [RW-1:0]   trial;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign din = den_i;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign din = den_q[k-1];
      assign sin = sb_q[k-1];
    end

    assign trial = RW'(din) << J;

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    // Hold divisor and sideband alongside
    always_ff @(posedge clk_i) begin
      den_q[k] <= din;
      sb_q[k]  <= sin;
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [RW-1:0] rin;
      logic [UW-1:0] qin;

      if (k == 0) begin : g_first
        assign rin = RW'(num_i[l]) << FRAC_BITS;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem_q[k-1][l];
        assign qin = quo_q[k-1][l];
      end

      // Subtract shifted divisor when it fits
      always_ff @(posedge clk_i) begin
        if (rin >= trial) begin
          rem_q[k][l] <= rin - trial;
          quo_q[k][l] <= qin | (UW'(1) << J);
        end else begin
          rem_q[k][l] <= rin;
          quo_q[k][l] <= qin;
        end
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = quo_q[UW-1][l];
  end

  assign valid_o = valid_q[UW-1];
  assign sb_o    = sb_q[UW-1];

endmodule

/* src/sph_spiky_gradient_core.sv */
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// Depth is set by the 32-stage square root and the FRAC_BITS + 1 stage divider.
// The receiver cannot stall; each result shows on done_o for one cycle.
// Reset clears pipeline valid bits and loads h = 1.0 and the default scale.
// ----------------------------------------------------------------------------
// sph_spiky_gradient_core
// Spiky kernel gradient for one particle-pair separation per cycle.
// ----------------------------------------------------------------------------
`include "sph_spiky_gradient_core_defines.svh"

module sph_spiky_gradient_core #(
  parameter int unsigned FRAC_BITS = spg_pkg::FracBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [spg_pkg::SepW-1:0] sep_x_i,
  input  logic signed [spg_pkg::SepW-1:0] sep_y_i,
  input  logic signed [spg_pkg::SepW-1:0] sep_z_i,
  input  logic                          cfg_we_i,
  input  logic [spg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [spg_pkg::ScaleW-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic signed [spg_pkg::GradW-1:0] grad_x_o,
  output logic signed [spg_pkg::GradW-1:0] grad_y_o,
  output logic signed [spg_pkg::GradW-1:0] grad_z_o,
  output logic                          in_range_o
);

  localparam int unsigned Lanes   = spg_pkg::NumLanes;
  localparam int unsigned SepW    = spg_pkg::SepW;
  localparam int unsigned SqW     = spg_pkg::SqW;
  localparam int unsigned RootW   = spg_pkg::RootW;
  localparam int unsigned DW      = spg_pkg::RadiusW;
  localparam int unsigned ScW     = spg_pkg::ScaleW;
  localparam int unsigned GW      = spg_pkg::GradW;
  localparam int unsigned UW      = FRAC_BITS + 1;
  localparam int unsigned QW      = 2 * DW - FRAC_BITS;
  localparam int unsigned MH      = (QW + 1) / 2;
  localparam int unsigned SH      = ScW / 2;
  localparam int unsigned PW      = ScW + 2 * MH;
  localparam int unsigned RsW     = PW - FRAC_BITS;
  localparam int unsigned DivSbW  = 1 + Lanes + DW;
  localparam int unsigned Latency = FRAC_BITS + 42;

  localparam logic [GW-1:0] PosLimit = {1'b0, {(GW-1){1'b1}}};
  localparam logic [GW-1:0] NegLimit = {1'b1, {(GW-1){1'b0}}};

  // Configuration registers
  logic [DW-1:0]  radius_q;
  logic [ScW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= spg_pkg::RadiusReset;
      scale_q  <= spg_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spg_pkg::CfgKernelRadius: radius_q <= cfg_data_i[DW-1:0];
        spg_pkg::CfgKernelScale:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept a transaction every cycle
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 0: component magnitudes and signs
  logic [Lanes-1:0][SepW-1:0] sep_w;
  logic [Lanes-1:0][SepW-1:0] mag_d;
  logic                       s0_valid_q;
  logic [Lanes-1:0][SepW-1:0] s0_mag_q;
  logic [Lanes-1:0]           s0_neg_q;

  assign sep_w[0] = sep_x_i;
  assign sep_w[1] = sep_y_i;
  assign sep_w[2] = sep_z_i;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      mag_d[l] = sep_w[l][SepW-1] ? (~sep_w[l] + SepW'(1)) : sep_w[l];
    end
  end

  // Stage 1: squares; stage 2: squared length
  logic                       s1_valid_q;
  logic [Lanes-1:0][SqW-1:0]  s1_sq_q;
  logic [Lanes-1:0][SepW-1:0] s1_mag_q;
  logic [Lanes-1:0]           s1_neg_q;
  logic                       s2_valid_q;
  logic [SqW-1:0]             s2_sq_q;
  spg_pkg::sqrt_sb_t          s2_sb_q;

  // Stage R: range test and h - r
  logic                       r_valid_q;
  logic                       r_in_range_q;
  logic [DW-1:0]              r_d_q;
  logic [RootW-1:0]           r_root_q;
  logic [Lanes-1:0][SepW-1:0] r_mag_q;
  logic [Lanes-1:0]           r_neg_q;

  // Stage Q, M, P, A
  logic                       q_valid_q;
  logic                       q_in_range_q;
  logic [Lanes-1:0]           q_neg_q;
  logic [QW-1:0]              q_q;
  logic [Lanes-1:0][UW-1:0]   q_u_q;
  logic                       m_valid_q;
  logic                       m_in_range_q;
  logic [Lanes-1:0]           m_neg_q;
  logic [Lanes-1:0][QW-1:0]   m_q;
  logic                       p_valid_q;
  logic                       p_in_range_q;
  logic [Lanes-1:0]           p_neg_q;
  logic [Lanes-1:0][SH+MH-1:0] p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  logic                       a_valid_q;
  logic                       a_in_range_q;
  logic [Lanes-1:0]           a_neg_q;
  logic [Lanes-1:0][PW-1:0]   a_prod_q;

  // Output registers
  logic                       done_q;
  logic                       in_range_q;
  logic [Lanes-1:0][GW-1:0]   grad_q;
  logic [Lanes-1:0][GW-1:0]   grad_d;

  // Square root pipeline
  logic                              sq_valid;
  logic [RootW-1:0]                  sq_root;
  logic [$bits(spg_pkg::sqrt_sb_t)-1:0] sq_sb_vec;
  spg_pkg::sqrt_sb_t                 sq_sb;

  spg_isqrt #(
    .SbW ($bits(spg_pkg::sqrt_sb_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .rad_i   (s2_sq_q),
    .sb_i    (s2_sb_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb_vec)
  );

  assign sq_sb = sq_sb_vec;

  // Divider pipeline: u = |c| * 2^F / r
  logic                     dv_valid;
  logic [Lanes-1:0][UW-1:0] dv_quo;
  logic [DivSbW-1:0]        dv_sb;
  logic                     dv_in_range;
  logic [Lanes-1:0]         dv_neg;
  logic [DW-1:0]            dv_d;

  spg_div3 #(
    .FRAC_BITS (FRAC_BITS),
    .SbW       (DivSbW)
  ) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid_q),
    .num_i   (r_mag_q),
    .den_i   (r_root_q),
    .sb_i    ({r_in_range_q, r_neg_q, r_d_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  assign dv_in_range = dv_sb[DivSbW-1];
  assign dv_neg      = dv_sb[DW +: Lanes];
  assign dv_d        = dv_sb[DW-1:0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      r_valid_q  <= 1'b0;
      q_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      p_valid_q  <= 1'b0;
      a_valid_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s0_valid_q <= accept;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      r_valid_q  <= sq_valid;
      q_valid_q  <= dv_valid;
      m_valid_q  <= q_valid_q;
      p_valid_q  <= m_valid_q;
      a_valid_q  <= p_valid_q;
      done_q     <= a_valid_q;
    end
  end

  // Datapath registers
  logic [2*DW-1:0] dd_w;
  assign dd_w = (2*DW)'(dv_d) * (2*DW)'(dv_d);

  always_ff @(posedge clk_i) begin
    // Stage 0
    s0_mag_q <= mag_d;
    for (int l = 0; l < Lanes; l++) begin
      s0_neg_q[l] <= sep_w[l][SepW-1];
    end
    // Stage 1
    for (int l = 0; l < Lanes; l++) begin
      s1_sq_q[l] <= SqW'(s0_mag_q[l]) * SqW'(s0_mag_q[l]);
    end
    s1_mag_q <= s0_mag_q;
    s1_neg_q <= s0_neg_q;
    // Stage 2
    s2_sq_q     <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    s2_sb_q.mag <= s1_mag_q;
    s2_sb_q.neg <= s1_neg_q;
    // Stage R
    r_in_range_q <= (sq_root != '0) && (sq_root < RootW'(radius_q));
    r_d_q        <= radius_q - sq_root[DW-1:0];
    r_root_q     <= sq_root;
    r_mag_q      <= sq_sb.mag;
    r_neg_q      <= sq_sb.neg;
    // Stage Q: q = (h - r)^2 / 2^F
    q_q          <= dd_w[2*DW-1:FRAC_BITS];
    q_u_q        <= dv_quo;
    q_neg_q      <= dv_neg;
    q_in_range_q <= dv_in_range;
    // Stage M: m = q * u / 2^F
    for (int l = 0; l < Lanes; l++) begin
      m_q[l] <= QW'(((QW+UW)'(q_q) * (QW+UW)'(q_u_q[l])) >> FRAC_BITS);
    end
    m_neg_q      <= q_neg_q;
    m_in_range_q <= q_in_range_q;
    // Stage P: partial products of scale * m
    for (int l = 0; l < Lanes; l++) begin
      p_ll_q[l] <= (SH+MH)'(scale_q[SH-1:0]) * (SH+MH)'(m_q[l][MH-1:0]);
      p_lh_q[l] <= (SH+MH)'(scale_q[SH-1:0]) * (SH+MH)'((2*MH)'(m_q[l]) >> MH);
      p_hl_q[l] <= (SH+MH)'(scale_q[ScW-1:SH]) * (SH+MH)'(m_q[l][MH-1:0]);
      p_hh_q[l] <= (SH+MH)'(scale_q[ScW-1:SH]) * (SH+MH)'((2*MH)'(m_q[l]) >> MH);
    end
    p_neg_q      <= m_neg_q;
    p_in_range_q <= m_in_range_q;
    // Stage A: combine partial products
    for (int l = 0; l < Lanes; l++) begin
      a_prod_q[l] <= PW'(p_ll_q[l]) + (PW'(p_lh_q[l]) << MH) +
                     (PW'(p_hl_q[l]) << SH) + (PW'(p_hh_q[l]) << (SH + MH));
    end
    a_neg_q      <= p_neg_q;
    a_in_range_q <= p_in_range_q;
    // Output stage
    grad_q     <= grad_d;
    in_range_q <= a_in_range_q;
  end

  // Saturate, apply the opposite sign, zero when out of range
  always_comb begin
    logic [RsW-1:0] res;
    logic [GW-1:0]  lim;
    logic [GW-1:0]  mag;
    for (int l = 0; l < Lanes; l++) begin
      res = a_prod_q[l][PW-1:FRAC_BITS];
      lim = a_neg_q[l] ? PosLimit : NegLimit;
      mag = (res > RsW'(lim)) ? lim : res[GW-1:0];
      if (!a_in_range_q) begin
        grad_d[l] = '0;
      end else if (a_neg_q[l]) begin
        grad_d[l] = mag;
      end else begin
        grad_d[l] = GW'(0) - mag;
      end
    end
  end

  assign done_o     = done_q;
  assign in_range_o = in_range_q;
  assign grad_x_o   = grad_q[0];
  assign grad_y_o   = grad_q[1];
  assign grad_z_o   = grad_q[2];

  // Assertions
  `SPG_ASSERT_IMPLIES(a_done_latency, accept, ##Latency done_o,
    "accepted transaction did not complete at the pipeline latency")
  `SPG_ASSERT_NEVER(a_no_spurious, done_o && !$past(accept, Latency),
    "result strobe without a matching accepted transaction")
  `SPG_ASSERT_IMPLIES(a_zero_out_of_range, done_o && !in_range_o,
    grad_x_o == '0 && grad_y_o == '0 && grad_z_o == '0,
    "out-of-range result has a nonzero gradient")
  `SPG_ASSERT_IMPLIES(a_range_margin, r_valid_q && r_in_range_q, r_d_q != '0,
    "in-range item with zero distance to the kernel radius")

endmodule
